### hw/rtl/tcc_pkg.sv
package tcc_pkg;

   localparam int COL_W   = 8;
   localparam int ROW_W   = 8;
   localparam int GLYPH_W = 7;
   localparam int COLOR_W = 32;
   localparam int CODE_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int TAB_SPACING = 4;

   localparam logic [COL_W-1:0]   COLUMNS_RESET = 8'd80;
   localparam logic [ROW_W-1:0]   ROWS_RESET    = 8'd25;
   localparam logic [COLOR_W-1:0] TEXT_RESET    = 32'h00FF_FFFF;
   localparam logic [COLOR_W-1:0] BACK_RESET    = 32'h0000_0000;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TEXT_COLOR   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_COLOR   = 2'd3;

   // character codes
   localparam logic [CODE_W-1:0] CHAR_BS    = 8'd8;
   localparam logic [CODE_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CODE_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CODE_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CODE_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CODE_W-1:0] CHAR_TILDE = 8'd126;

   localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 7'd32;

   typedef enum logic [0:0] {
      CMD_WRITE  = 1'b0,
      CMD_SCROLL = 1'b1
   } cmd_kind_type;

   // commands raised by one character
   typedef struct packed {
      logic                wr;
      logic                scr;
      logic [COL_W-1:0]    wr_column;
      logic [ROW_W-1:0]    wr_row;
      logic [GLYPH_W-1:0]  wr_glyph;
   } step_type;

   localparam int TAB_ENTRIES = 2 ** COL_W;

   typedef logic [COL_W:0] tab_table_type [TAB_ENTRIES];

   // next tab stop for every column, built at elaboration
   function automatic tab_table_type build_tab_table();
      tab_table_type t;
      for (int i = 0; i < TAB_ENTRIES; i++) begin
         t[i] = (COL_W+1)'(i + TAB_SPACING - (i % TAB_SPACING));
      end
      return t;
   endfunction

   localparam tab_table_type TAB_TABLE = build_tab_table();

endpackage

### hw/rtl/tcc_cursor.sv
module tcc_cursor
   import tcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CODE_W-1:0] code,
   input  logic [COL_W-1:0]  grid_columns,
   input  logic [ROW_W-1:0]  grid_rows,
   output step_type          step
);

   logic [COL_W-1:0] column_pos_ff, column_pos_in;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;

   logic [COL_W-1:0] cols_eff;
   logic [ROW_W-1:0] rows_eff;
   logic [COL_W:0]   col_n;
   logic [ROW_W:0]   row_n;

   assign cols_eff = (grid_columns == '0) ? COL_W'(1) : grid_columns;
   assign rows_eff = (grid_rows == '0) ? ROW_W'(1) : grid_rows;

   always_comb begin
      step           = '0;
      step.wr_row    = row_pos_ff;
      step.wr_column = column_pos_ff;
      col_n          = {1'b0, column_pos_ff};
      row_n          = {1'b0, row_pos_ff};

      case (code) inside
         CHAR_LF: begin
            col_n = '0;
            row_n = row_n + 1'b1;
         end
         CHAR_CR: begin
            col_n = '0;
         end
         CHAR_TAB: begin
            col_n = TAB_TABLE[column_pos_ff];
         end
         CHAR_BS: begin
            if (column_pos_ff != '0) begin
               col_n          = col_n - 1'b1;
               step.wr        = 1'b1;
               step.wr_column = column_pos_ff - 1'b1;
               step.wr_glyph  = BLANK_GLYPH;
            end
         end
         [CHAR_SPACE:CHAR_TILDE]: begin
            step.wr       = 1'b1;
            step.wr_glyph = code[GLYPH_W-1:0];
            col_n         = col_n + 1'b1;
         end
         default: begin
         end
      endcase

      // wrap past the last column
      if (col_n >= {1'b0, cols_eff}) begin
         col_n = '0;
         row_n = row_n + 1'b1;
      end

      // past the last row: scroll and pin
      if (row_n >= {1'b0, rows_eff}) begin
         step.scr = 1'b1;
         row_n    = {1'b0, rows_eff - 1'b1};
      end

      column_pos_in = col_n[COL_W-1:0];
      row_pos_in    = row_n[ROW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
      end else if (accept) begin
         column_pos_ff <= column_pos_in;
         row_pos_ff    <= row_pos_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_cursor_inside: assert property (@(posedge clock) disable iff (reset)
      accept |=> (row_pos_ff < $past(rows_eff)) && (column_pos_ff < $past(cols_eff)))
      else $error("cursor left the grid after a character");

   a_bs_blank: assert property (@(posedge clock) disable iff (reset)
      (accept && code == CHAR_BS && column_pos_ff != '0) |->
         (step.wr && step.wr_glyph == BLANK_GLYPH))
      else $error("backspace did not blank a cell");

   a_scroll_pins: assert property (@(posedge clock) disable iff (reset)
      (accept && step.scr) |=> (row_pos_ff == $past(rows_eff) - 1'b1))
      else $error("scroll did not pin the cursor to the last row");
`endif

endmodule

### hw/rtl/text_console_cursor_control.sv
// Text console cursor control. Each req beat carries one character byte; the block
// moves a (column, row) cursor over a grid set by grid_columns/grid_rows (0 acts as 1)
// and sends cell commands on rsp: a glyph write into a cell, or a scroll-up that clears
// the bottom line. A character gives zero, one or two beats (write, then scroll), the
// final one flagged by last_of_run. A new character is taken every cycle while each
// raises at most one command and rsp is not stalled; one that raises a write and a
// scroll holds off the next character until its write leaves, as the single output
// register hands the pending commands out one per beat; commands wait in pend_ff first.
// The csr registers are to be written only while no character is in flight.
module text_console_cursor_control
   import tcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CODE_W-1:0]     req_char_code,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_command_kind,
   output logic [COL_W-1:0]      rsp_cell_column,
   output logic [ROW_W-1:0]      rsp_cell_row,
   output logic [GLYPH_W-1:0]    rsp_glyph_code,
   output logic [COLOR_W-1:0]    rsp_fore_value,
   output logic [COLOR_W-1:0]    rsp_back_value,
   output logic                  rsp_last_of_run,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [COL_W-1:0]   grid_columns_ff;
   logic [ROW_W-1:0]   grid_rows_ff;
   logic [COLOR_W-1:0] text_color_ff;
   logic [COLOR_W-1:0] back_color_ff;

   step_type step;
   step_type pend_ff;

   logic               rsp_valid_ff;
   cmd_kind_type       rsp_kind_ff;
   logic [COL_W-1:0]   rsp_column_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [GLYPH_W-1:0] rsp_glyph_ff;
   logic [COLOR_W-1:0] rsp_fore_ff;
   logic [COLOR_W-1:0] rsp_back_ff;
   logic               rsp_last_ff;

   logic accept;
   logic out_free;
   logic pend_any;
   logic pend_both;
   logic move;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= COLUMNS_RESET;
         grid_rows_ff    <= ROWS_RESET;
         text_color_ff   <= TEXT_RESET;
         back_color_ff   <= BACK_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_GRID_COLUMNS: grid_columns_ff <= csr_data[COL_W-1:0];
            REG_GRID_ROWS:    grid_rows_ff    <= csr_data[ROW_W-1:0];
            REG_TEXT_COLOR:   text_color_ff   <= csr_data[COLOR_W-1:0];
            REG_BACK_COLOR:   back_color_ff   <= csr_data[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tcc_cursor u_cursor (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .code         (req_char_code),
      .grid_columns (grid_columns_ff),
      .grid_rows    (grid_rows_ff),
      .step         (step)
   );

   assign pend_any  = pend_ff.wr | pend_ff.scr;
   assign pend_both = pend_ff.wr & pend_ff.scr;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign move      = out_free & pend_any;

   // take a character once the pending commands are gone by the end of this cycle
   assign req_stall = ~(~pend_any | (move & ~pend_both));
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff.wr  <= 1'b0;
         pend_ff.scr <= 1'b0;
      end else if (accept) begin
         pend_ff.wr  <= step.wr;
         pend_ff.scr <= step.scr;
      end else if (move) begin
         if (pend_ff.wr) begin
            pend_ff.wr <= 1'b0;
         end else begin
            pend_ff.scr <= 1'b0;
         end
      end
      if (accept) begin
         pend_ff.wr_column <= step.wr_column;
         pend_ff.wr_row    <= step.wr_row;
         pend_ff.wr_glyph  <= step.wr_glyph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_back_ff <= back_color_ff;
         if (pend_ff.wr) begin
            rsp_kind_ff   <= CMD_WRITE;
            rsp_column_ff <= pend_ff.wr_column;
            rsp_row_ff    <= pend_ff.wr_row;
            rsp_glyph_ff  <= pend_ff.wr_glyph;
            rsp_fore_ff   <= text_color_ff;
            rsp_last_ff   <= ~pend_ff.scr;
         end else begin
            rsp_kind_ff   <= CMD_SCROLL;
            rsp_column_ff <= '0;
            rsp_row_ff    <= '0;
            rsp_glyph_ff  <= '0;
            rsp_fore_ff   <= '0;
            rsp_last_ff   <= 1'b1;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_kind = rsp_kind_ff;
   assign rsp_cell_column  = rsp_column_ff;
   assign rsp_cell_row     = rsp_row_ff;
   assign rsp_glyph_code   = rsp_glyph_ff;
   assign rsp_fore_value   = rsp_fore_ff;
   assign rsp_back_value   = rsp_back_ff;
   assign rsp_last_of_run  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> ~pend_both)
      else $error("character taken over two pending commands");

   a_scroll_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == CMD_SCROLL) |->
         (rsp_last_ff && rsp_column_ff == '0 && rsp_row_ff == '0 &&
          rsp_glyph_ff == '0 && rsp_fore_ff == '0))
      else $error("scroll beat malformed");

   a_write_glyph: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == CMD_WRITE) |-> (rsp_glyph_ff >= BLANK_GLYPH))
      else $error("write beat carries a control code");
`endif

endmodule

### bench/text_console_cursor_control_checker.sv
`timescale 1ns / 1ps

module text_console_cursor_control_checker
   import tcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [CODE_W-1:0]     req_char_code,

   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_command_kind,
   input  logic [COL_W-1:0]      rsp_cell_column,
   input  logic [ROW_W-1:0]      rsp_cell_row,
   input  logic [GLYPH_W-1:0]    rsp_glyph_code,
   input  logic [COLOR_W-1:0]    rsp_fore_value,
   input  logic [COLOR_W-1:0]    rsp_back_value,
   input  logic                  rsp_last_of_run,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,

   output int                    pending_count,
   output int                    fail_count,
   output int                    write_count,
   output int                    scroll_count
);

   localparam int MAX_REPORTS = 50;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [COL_W-1:0]     column;
      logic [ROW_W-1:0]     row;
      logic [GLYPH_W-1:0]   glyph;
      logic [COLOR_W-1:0]   fore;
      logic [COLOR_W-1:0]   back;
      logic                 last;
   } cell_cmd_type;

   cell_cmd_type expected_cmds[$];

   // shadow of the csr registers and the cursor
   logic [COL_W-1:0]   grid_cols;
   logic [ROW_W-1:0]   grid_rows;
   logic [COLOR_W-1:0] text_color;
   logic [COLOR_W-1:0] back_color;
   logic [COL_W-1:0]   cursor_col;
   logic [ROW_W-1:0]   cursor_row;

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("[%0t] %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   function automatic cell_cmd_type cell_write(input int col, input int row,
                                               input logic [GLYPH_W-1:0] glyph);
      cell_cmd_type c;
      c.kind   = CMD_WRITE;
      c.column = COL_W'(col);
      c.row    = ROW_W'(row);
      c.glyph  = glyph;
      c.fore   = text_color;
      c.back   = back_color;
      c.last   = 1'b0;
      return c;
   endfunction

   // moves the cursor for one character and queues the commands it raises
   task automatic predict_commands(input logic [CODE_W-1:0] code);
      cell_cmd_type batch [2];
      int n;
      int cols;
      int rows;
      int col;
      int row;
      n    = 0;
      cols = (grid_cols == '0) ? 1 : int'(grid_cols);
      rows = (grid_rows == '0) ? 1 : int'(grid_rows);
      col  = int'(cursor_col);
      row  = int'(cursor_row);

      if (code == CHAR_LF) begin
         col = 0;
         row++;
      end else if (code == CHAR_CR) begin
         col = 0;
      end else if (code == CHAR_TAB) begin
         col = col + TAB_SPACING - (col % TAB_SPACING);
      end else if (code == CHAR_BS) begin
         if (col > 0) begin
            col--;
            batch[n] = cell_write(col, row, BLANK_GLYPH);
            n++;
         end
      end else if (code >= CHAR_SPACE && code <= CHAR_TILDE) begin
         batch[n] = cell_write(col, row, code[GLYPH_W-1:0]);
         n++;
         col++;
      end

      // wrap and scroll run on every character, ignored ones too
      if (col >= cols) begin
         col = 0;
         row++;
      end
      if (row >= rows) begin
         batch[n] = '{kind: CMD_SCROLL, column: '0, row: '0, glyph: '0,
                      fore: '0, back: back_color, last: 1'b0};
         n++;
         row = rows - 1;
      end

      for (int i = 0; i < n; i++) begin
         batch[i].last = (i == n - 1);
         expected_cmds.push_back(batch[i]);
      end
      cursor_col = COL_W'(col);
      cursor_row = ROW_W'(row);
   endtask

   always @(posedge clock) begin : watch
      cell_cmd_type want;
      if (reset) begin
         grid_cols  = COLUMNS_RESET;
         grid_rows  = ROWS_RESET;
         text_color = TEXT_RESET;
         back_color = BACK_RESET;
         cursor_col = '0;
         cursor_row = '0;
         expected_cmds.delete();
         pending_count <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_GRID_COLUMNS: grid_cols  = csr_data[COL_W-1:0];
               REG_GRID_ROWS:    grid_rows  = csr_data[ROW_W-1:0];
               REG_TEXT_COLOR:   text_color = csr_data[COLOR_W-1:0];
               REG_BACK_COLOR:   back_color = csr_data[COLOR_W-1:0];
               default: ;
            endcase
         end

         // compare before predicting: a beat never belongs to a char taken this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               report($sformatf("command beat with nothing expected: kind %0d col %0d row %0d",
                                rsp_command_kind, rsp_cell_column, rsp_cell_row));
            end else begin
               want = expected_cmds.pop_front();
               check_field("command_kind", rsp_command_kind, want.kind);
               check_field("cell_column", rsp_cell_column, want.column);
               check_field("cell_row", rsp_cell_row, want.row);
               check_field("glyph_code", rsp_glyph_code, want.glyph);
               check_field("fore_value", rsp_fore_value, want.fore);
               check_field("back_value", rsp_back_value, want.back);
               check_field("last_of_run", rsp_last_of_run, want.last);
               if (want.kind == CMD_SCROLL)
                  scroll_count++;
               else
                  write_count++;
            end
         end

         if (req_valid && !req_stall)
            predict_commands(req_char_code);

         pending_count <= expected_cmds.size();
      end
   end

endmodule

### bench/text_console_cursor_control_tb.sv
`timescale 1ns / 1ps

module text_console_cursor_control_tb;
   import tcc_pkg::*;

   localparam int RESET_CYCLES     = 12;
   localparam int NUM_SETTINGS     = 10;
   localparam int PHASE_CHARS      = 125;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT      = 5000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int TIMEOUT_CYCLES   = 1_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CODE_W-1:0]     req_char_code = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_command_kind;
   logic [COL_W-1:0]      rsp_cell_column;
   logic [ROW_W-1:0]      rsp_cell_row;
   logic [GLYPH_W-1:0]    rsp_glyph_code;
   logic [COLOR_W-1:0]    rsp_fore_value;
   logic [COLOR_W-1:0]    rsp_back_value;
   logic                  rsp_last_of_run;

   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int pending_count;
   int fail_count;
   int write_count;
   int scroll_count;

   logic long_hold = 1'b0;
   bit   hold_go = 1'b0;
   bit   steady_sender = 1'b0;
   int   stall_left = 0;
   int   open_left = 0;
   int   chars_sent = 0;
   int   settings_run = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   text_console_cursor_control dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_kind (rsp_command_kind),
      .rsp_cell_column  (rsp_cell_column),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_fore_value   (rsp_fore_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   text_console_cursor_control_checker cmd_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_kind (rsp_command_kind),
      .rsp_cell_column  (rsp_cell_column),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_glyph_code   (rsp_glyph_code),
      .rsp_fore_value   (rsp_fore_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .pending_count    (pending_count),
      .fail_count       (fail_count),
      .write_count      (write_count),
      .scroll_count     (scroll_count)
   );

   // mostly short idles, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CODE_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return CODE_W'($urandom_range(32, 126));
      if (r < 65) return CHAR_LF;
      if (r < 70) return CHAR_CR;
      if (r < 78) return CHAR_TAB;
      if (r < 86) return CHAR_BS;
      return CODE_W'($urandom_range(0, 255));
   endfunction

   // {columns, rows} per setting: extremes, zero sizes and a few in between
   function automatic logic [15:0] grid_choice(input int p);
      case (p)
         0:       return {8'd255, 8'd255};
         1:       return {8'd1,   8'd1};
         2:       return {8'd0,   8'd0};
         3:       return {8'd3,   8'd7};
         4:       return {8'd255, 8'd1};
         5:       return {8'd1,   8'd255};
         6:       return {8'd0,   8'd9};
         7:       return {8'd17,  8'd5};
         8:       return {8'd80,  8'd25};
         default: return {8'd2,   8'd3};
      endcase
   endfunction

   // receiver side: random stalls, with open stretches, plus the forced hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
         open_left  = 0;
      end else begin
         if (stall_left > 0) begin
            stall_left--;
         end else if (open_left > 0) begin
            open_left--;
         end else begin
            stall_left = idle_len();
            open_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(0, 4);
         end
         rsp_stall <= long_hold || (stall_left > 0);
      end
   end

   initial begin : rsp_hold
      wait (hold_go);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic send_char(input logic [CODE_W-1:0] code);
      int gap;
      gap = steady_sender ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
   endtask

   // stop sending until every expected command is back, then let silent chars finish
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [COL_W-1:0] cols, input logic [ROW_W-1:0] rows,
                                input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      csr_beat(REG_GRID_COLUMNS, CSR_DATA_W'(cols));
      csr_beat(REG_GRID_ROWS, CSR_DATA_W'(rows));
      csr_beat(REG_TEXT_COLOR, fg);
      csr_beat(REG_BACK_COLOR, bg);
      csr_write_en <= 1'b0;
      settings_run++;
   endtask

   initial begin : stimulus
      logic [15:0]        grid;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic [CODE_W-1:0]  code;
      int                 count;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset grid: backspace at column zero, printable ends, ignored codes
      send_char(CHAR_BS);    send_char(CHAR_SPACE); send_char(CHAR_TILDE);
      send_char(8'd127);     send_char(8'd255);     send_char(8'd0);
      send_char(8'd31);      send_char(8'd128);     send_char(CHAR_BS);
      send_char(CHAR_TAB);   send_char("A");        send_char(CHAR_CR);
      send_char(CHAR_LF);

      // 6x2 grid, cursor at column 0 of row 1
      drain();
      load_settings(8'd6, 8'd2, 32'hFFFF_FFFF, 32'h0000_0000);
      send_char(CHAR_TAB);   send_char("B");
      send_char("C");        // write in the last column, then wrap and scroll
      send_char(CHAR_TAB);
      send_char(CHAR_TAB);   // tab past the last column scrolls
      send_char(CHAR_LF);    send_char(CHAR_BS);    send_char("D");
      send_char(CHAR_BS);    send_char(CHAR_CR);    send_char(8'h55);
      send_char(8'hAA);

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         drain();
         grid = grid_choice(p);
         case (p % 3)
            0:       begin fg = '0;          bg = $urandom(); end
            1:       begin fg = '1;          bg = '0;         end
            default: begin fg = $urandom(); bg = '1;         end
         endcase
         load_settings(grid[15:8], grid[7:0], fg, bg);
         steady_sender = ($urandom_range(0, 3) == 0);
         // 1x1 grid: most chars raise two beats, so the hold backs up the input
         if (p == 1)
            hold_go = 1'b1;
         count = 0;
         while (count < PHASE_CHARS) begin
            code = pick_char();
            send_char(code);
            count++;
            if (p == 5 && count == PHASE_CHARS / 2)
               drain();
         end
      end

      drain();
      $display("covered %0d characters over %0d grid settings incl. zero and full sizes",
               chars_sent, settings_run);
      $display("checked %0d cell writes and %0d scrolls", write_count, scroll_count);
      if (pending_count != 0)
         $display("%0d expected commands never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("text_console_cursor_control_tb: PASS");
      end else begin
         $display("text_console_cursor_control_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #(2 * TIMEOUT_CYCLES);
      $display("timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("text_console_cursor_control_tb: FAIL");
      $finish;
   end

endmodule

### files.f
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_cursor.sv
hw/rtl/text_console_cursor_control.sv
bench/text_console_cursor_control_checker.sv
bench/text_console_cursor_control_tb.sv
